FILE: rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared constants, command and status types for the trimmed window stats block.
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int unsigned WINDOW_DEF = 8;
    localparam int unsigned TRIM_DEF   = 1;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned STAT_W   = 24;
    localparam int unsigned COUNT_W  = 4;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic apply;
        logic sort_start;
        logic sum_start;
        logic div_start;
        logic sqrt_start;
        logic capture;
    } tws_cmd_t;

    typedef struct packed {
        logic sort_done;
        logic sum_done;
        logic div_done;
        logic sqrt_done;
    } tws_status_t;

endpackage

FILE: rtl/tws_ctrl.sv
// ----------------------------------------------------------------------------
// tws_ctrl
// Sequencer: walks each request through update, sort, sums, divide and root.
// ----------------------------------------------------------------------------
module tws_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tws_pkg::tws_cmd_t    cmd,
    input  tws_pkg::tws_status_t status
);
    import tws_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SORT = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_LOAD = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic       finish;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        finish      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.apply  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.sort_start = 1'b1;
                state_next     = ST_SORT;
            end
            ST_SORT: begin
                if (status.sort_done) begin
                    cmd.sum_start = 1'b1;
                    state_next    = ST_SUM;
                end
            end
            ST_SUM: begin
                if (status.sum_done) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (status.sqrt_done && !mvalid_reg) begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        cmd.capture = finish;
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end
        if (finish) begin
            mvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

FILE: rtl/tws_datapath.sv
// ----------------------------------------------------------------------------
// tws_datapath
// Ring, odd-even transposition sort, sums, restoring divider and bitwise root.
// ----------------------------------------------------------------------------
module tws_datapath #(
    parameter int unsigned WINDOW = tws_pkg::WINDOW_DEF,
    parameter int unsigned TRIM   = tws_pkg::TRIM_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tws_pkg::tws_cmd_t               cmd,
    output tws_pkg::tws_status_t            status,
    input  logic                            s_op,
    input  logic [tws_pkg::SAMPLE_W-1:0]    s_sample,
    output logic [tws_pkg::COUNT_W-1:0]     m_window_fill,
    output logic [tws_pkg::COUNT_W-1:0]     m_samples_used,
    output logic [tws_pkg::STAT_W-1:0]      m_trimmed_mean,
    output logic [tws_pkg::STAT_W-1:0]      m_trimmed_stdev
);
    import tws_pkg::*;

    localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned FILL_W = $clog2(WINDOW + 1);
    localparam int unsigned S1_W   = SAMPLE_W + FILL_W;
    localparam int unsigned S2_W   = 2 * SAMPLE_W + FILL_W;
    localparam int unsigned NUM_W  = S2_W + FILL_W + 16;
    localparam int unsigned DEN_W  = 2 * FILL_W;
    localparam int unsigned QW     = NUM_W;
    localparam int unsigned RT_W   = (QW + 1) / 2;
    localparam int unsigned XW     = 2 * RT_W;
    localparam int unsigned CNT_W  = $clog2(QW + 1);
    localparam int unsigned MIN_TR = 2 * TRIM + 2;
    localparam bit          CAN_TRIM = (MIN_TR <= WINDOW);

    logic [SAMPLE_W-1:0] ring_reg [WINDOW];
    logic [SAMPLE_W-1:0] srt_reg  [WINDOW];
    logic [SLOT_W-1:0]   slot_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   pass_reg;
    logic                sorting_reg;

    logic [FILL_W-1:0]   idx_reg, lo_w, hi_w, n_w;
    logic                trim_w;
    logic                summing_reg;
    logic                sdone_reg;
    logic [S1_W-1:0]     s1_reg;
    logic [S2_W-1:0]     s2_reg;
    logic [2*SAMPLE_W-1:0] sq_w;
    logic [SAMPLE_W-1:0] cur_w;

    logic [CNT_W-1:0]    dcnt_reg;
    logic                dbusy_reg, mode_reg;
    logic [QW-1:0]       dq_reg;
    logic [DEN_W-1:0]    dden_reg;
    logic [DEN_W:0]      drem_reg, dtrial;
    logic [QW-1:0]       mean_q_reg;

    logic [CNT_W-1:0]    rcnt_reg;
    logic                rbusy_reg;
    logic [XW-1:0]       rx_reg;
    logic [RT_W-1:0]     root_reg;
    logic [RT_W+1:0]     rrem_reg, rtrial, rshift;

    logic [S2_W+FILL_W-1:0] ns2_w;
    logic [2*S1_W-1:0]      s1sq_reg;
    logic [S2_W+FILL_W-1:0] var_reg;

    assign trim_w = CAN_TRIM && (fill_reg >= FILL_W'(MIN_TR));
    assign n_w  = trim_w ? fill_reg - FILL_W'(2 * TRIM) : fill_reg;
    assign lo_w = trim_w ? FILL_W'(TRIM) : '0;
    assign hi_w = lo_w + n_w;

    // ring update and odd-even sort, one pass per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg    <= '0;
            fill_reg    <= '0;
            sorting_reg <= 1'b0;
            pass_reg    <= '0;
        end else if (cmd.apply) begin
            if (s_op == OP_CLEAR) begin
                slot_reg <= '0;
                fill_reg <= '0;
            end else begin
                ring_reg[slot_reg] <= s_sample;
                slot_reg <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                if (fill_reg < FILL_W'(WINDOW)) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            sorting_reg <= 1'b0;
            pass_reg    <= '0;
        end else if (cmd.sort_start) begin
            sorting_reg <= 1'b1;
            pass_reg    <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                srt_reg[i] <= ring_reg[i];
            end
        end else if (sorting_reg) begin
            for (int i = 0; i + 1 < WINDOW; i++) begin
                if ((i % 2) == int'(pass_reg[0]) && (i + 1) < int'(fill_reg)
                    && srt_reg[i] > srt_reg[i+1]) begin
                    srt_reg[i]   <= srt_reg[i+1];
                    srt_reg[i+1] <= srt_reg[i];
                end
            end
            pass_reg <= pass_reg + 1'b1;
            if (pass_reg == FILL_W'(WINDOW - 1)) begin
                sorting_reg <= 1'b0;
            end
        end
    end

    assign status.sort_done = sorting_reg && (pass_reg == FILL_W'(WINDOW - 1));

    // sums over kept entries
    assign cur_w = srt_reg[idx_reg[SLOT_W-1:0]];
    assign sq_w  = cur_w * cur_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            summing_reg <= 1'b0;
            sdone_reg   <= 1'b0;
            idx_reg     <= '0;
        end else begin
            sdone_reg <= summing_reg && (idx_reg >= hi_w);
            if (cmd.sum_start) begin
                summing_reg <= 1'b1;
                idx_reg     <= lo_w;
                s1_reg      <= '0;
                s2_reg      <= '0;
            end else if (summing_reg) begin
                if (idx_reg >= hi_w) begin
                    summing_reg <= 1'b0;
                end else begin
                    s1_reg  <= s1_reg + S1_W'(cur_w);
                    s2_reg  <= s2_reg + S2_W'(sq_w);
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sum_start) begin
            s1sq_reg <= '0;
        end else if (summing_reg && idx_reg >= hi_w) begin
            s1sq_reg <= s1_reg * s1_reg;
        end
    end

    assign status.sum_done = sdone_reg;
    assign ns2_w = s2_reg * n_w;

    // divider: first mean = (s1<<8)/n, then variance = (num<<16)/den
    assign dtrial = {drem_reg[DEN_W-1:0], dq_reg[QW-1]} - {1'b0, dden_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            mode_reg  <= 1'b0;
            dcnt_reg  <= '0;
        end else if (cmd.div_start) begin
            var_reg   <= ns2_w - (S2_W+FILL_W)'(s1sq_reg);
            dbusy_reg <= 1'b1;
            mode_reg  <= 1'b0;
            dcnt_reg  <= CNT_W'(QW);
            drem_reg  <= '0;
            dden_reg  <= DEN_W'(n_w);
            dq_reg    <= QW'({s1_reg, 8'h00});
        end else if (dbusy_reg) begin
            if (dcnt_reg != '0) begin
                if (!dtrial[DEN_W]) begin
                    drem_reg <= dtrial;
                    dq_reg   <= {dq_reg[QW-2:0], 1'b1};
                end else begin
                    drem_reg <= {drem_reg[DEN_W-1:0], dq_reg[QW-1]};
                    dq_reg   <= {dq_reg[QW-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 1'b1;
            end else if (!mode_reg) begin
                mean_q_reg <= dq_reg;
                mode_reg   <= 1'b1;
                dcnt_reg   <= CNT_W'(QW);
                drem_reg   <= '0;
                dden_reg   <= DEN_W'(n_w) * DEN_W'(n_w - 1'b1);
                dq_reg     <= (n_w > FILL_W'(1)) ? QW'({var_reg, 16'h0000}) : '0;
                if (n_w <= FILL_W'(1)) begin
                    dden_reg <= DEN_W'(1);
                end
            end else begin
                dbusy_reg <= 1'b0;
            end
        end
    end

    assign status.div_done = !dbusy_reg && mode_reg;

    // restoring square root, one result bit per cycle
    assign rshift = {rrem_reg[RT_W-1:0], rx_reg[XW-1 -: 2]};
    assign rtrial = rshift - {root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rbusy_reg <= 1'b0;
            rcnt_reg  <= '0;
        end else if (cmd.sqrt_start) begin
            rbusy_reg <= 1'b1;
            rcnt_reg  <= CNT_W'(RT_W);
            rx_reg    <= XW'(dq_reg);
            root_reg  <= '0;
            rrem_reg  <= '0;
        end else if (rbusy_reg) begin
            if (rcnt_reg != '0) begin
                rx_reg <= {rx_reg[XW-3:0], 2'b00};
                if (!rtrial[RT_W+1]) begin
                    rrem_reg <= rtrial;
                    root_reg <= {root_reg[RT_W-2:0], 1'b1};
                end else begin
                    rrem_reg <= rshift;
                    root_reg <= {root_reg[RT_W-2:0], 1'b0};
                end
                rcnt_reg <= rcnt_reg - 1'b1;
            end else begin
                rbusy_reg <= 1'b0;
            end
        end
    end

    assign status.sqrt_done = !rbusy_reg && rcnt_reg == '0;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            m_window_fill   <= COUNT_W'(fill_reg);
            m_samples_used  <= COUNT_W'(n_w);
            m_trimmed_mean  <= (n_w == '0) ? '0 : STAT_W'(mean_q_reg);
            m_trimmed_stdev <= (n_w > FILL_W'(1)) ? STAT_W'(root_reg) : '0;
        end
    end

endmodule

FILE: rtl/trimmed_window_stats.sv
// ----------------------------------------------------------------------------
// trimmed_window_stats
// Trimmed mean and sample deviation over a sliding window of samples.
// ----------------------------------------------------------------------------
// One request at a time: the next request is taken only once the previous
// one has finished. At the default window each request updates the ring,
// loads the sort, runs WINDOW odd-even passes, sums the n samples used,
// runs two 56-step restoring divides with a hand-off and a 28-step square
// root; the divides are the longest part of it. A result left waiting on
// m_ready holds the next request at the root stage.
module trimmed_window_stats #(
    parameter int unsigned WINDOW = tws_pkg::WINDOW_DEF,
    parameter int unsigned TRIM   = tws_pkg::TRIM_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [tws_pkg::SAMPLE_W-1:0] s_sample,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tws_pkg::COUNT_W-1:0]  m_window_fill,
    output logic [tws_pkg::COUNT_W-1:0]  m_samples_used,
    output logic [tws_pkg::STAT_W-1:0]   m_trimmed_mean,
    output logic [tws_pkg::STAT_W-1:0]   m_trimmed_stdev
);
    import tws_pkg::*;

    tws_cmd_t    cmd;
    tws_status_t status;

    tws_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    tws_datapath #(.WINDOW(WINDOW), .TRIM(TRIM)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_op            (s_op),
        .s_sample        (s_sample),
        .m_window_fill   (m_window_fill),
        .m_samples_used  (m_samples_used),
        .m_trimmed_mean  (m_trimmed_mean),
        .m_trimmed_stdev (m_trimmed_stdev)
    );

endmodule

FILE: rtl/tws_checker.sv
// ----------------------------------------------------------------------------
// tws_sva
// Port-level checks on the request and result channels.
// ----------------------------------------------------------------------------
module tws_sva (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_window_fill,
    input logic [3:0] m_samples_used
);
    a_used_le_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_samples_used <= m_window_fill)
        else $error("samples_used above window_fill");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_window_fill))
        else $error("result dropped while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

endmodule

bind trimmed_window_stats tws_sva u_chk (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_window_fill  (m_window_fill),
    .m_samples_used (m_samples_used)
);

FILE: bench/tws_checker.sv
// ----------------------------------------------------------------------------
// tws_checker
// Watches both channels of trimmed_window_stats, predicts the statistics of
// every accepted request from its own copy of the ring, and compares results.
// ----------------------------------------------------------------------------
module tws_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_op,
    input  logic [15:0] s_sample,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [3:0]  m_window_fill,
    input  logic [3:0]  m_samples_used,
    input  logic [23:0] m_trimmed_mean,
    input  logic [23:0] m_trimmed_stdev,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tws_pkg::*;

    localparam int WIN = 8;
    localparam int TRM = 1;

    typedef struct {
        logic [3:0]  fill;
        logic [3:0]  used;
        logic [23:0] mean;
        logic [23:0] stdev;
    } window_stats_t;

    logic [15:0]   ring [WIN];
    int unsigned   slot;
    int unsigned   fill;
    window_stats_t stats_q [$];

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic window_stats_t window_stats();
        window_stats_t   r;
        logic [15:0]     srt [WIN];
        logic [15:0]     v;
        int              j, lo, hi, n;
        longint unsigned s1, s2, num, den;
        s1 = 0;
        s2 = 0;
        for (int i = 0; i < fill; i++) srt[i] = ring[i];
        for (int i = 1; i < fill; i++) begin
            v = srt[i];
            j = i;
            while (j > 0 && srt[j-1] > v) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        lo = (fill >= 2 * TRM + 2) ? TRM : 0;
        hi = fill - lo;
        n = (fill > 0) ? hi - lo : 0;
        r.fill = 4'(fill);
        r.used = 4'(n);
        r.mean = '0;
        r.stdev = '0;
        if (n > 0) begin
            for (int i = lo; i < hi; i++) begin
                s1 += srt[i];
                s2 += longint'(srt[i]) * srt[i];
            end
            r.mean = 24'((s1 << 8) / n);
            if (n > 1) begin
                num = n * s2 - s1 * s1;
                den = n * (n - 1);
                r.stdev = 24'(int_sqrt((num << 16) / den));
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        window_stats_t e;
        if (!aresetn) begin
            slot = 0;
            fill = 0;
            fail_count = 0;
            stats_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (s_op == OP_PUSH) begin
                    ring[slot] = s_sample;
                    slot = (slot + 1) % WIN;
                    if (fill < WIN) fill = fill + 1;
                end else begin
                    fill = 0;
                    slot = 0;
                end
                stats_q.push_back(window_stats());
            end
            if (m_valid && m_ready) begin
                if (stats_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    e = stats_q.pop_front();
                    if (m_window_fill !== e.fill) begin
                        $error("window_fill exp %0d got %0d", e.fill, m_window_fill);
                        fail_count++;
                    end
                    if (m_samples_used !== e.used) begin
                        $error("samples_used exp %0d got %0d", e.used, m_samples_used);
                        fail_count++;
                    end
                    if (m_trimmed_mean !== e.mean) begin
                        $error("trimmed_mean exp %0h got %0h", e.mean, m_trimmed_mean);
                        fail_count++;
                    end
                    if (m_trimmed_stdev !== e.stdev) begin
                        $error("trimmed_stdev exp %0h got %0h", e.stdev, m_trimmed_stdev);
                        fail_count++;
                    end
                end
            end
        end
        pending = stats_q.size();
    end
endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random push/clear requests into trimmed_window_stats
// under several idle and stall patterns and reports the checker verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tws_pkg::*;

    localparam int LIMIT = 2_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = OP_PUSH;
    logic [15:0] s_sample = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_window_fill;
    logic [3:0]  m_samples_used;
    logic [23:0] m_trimmed_mean;
    logic [23:0] m_trimmed_stdev;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_req = 1'b0;
    int          hold_off = 0;
    int          cycles = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    trimmed_window_stats DUT (.*);

    tws_checker checker_i (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("trimmed_window_stats test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_req && hold_off < 400) begin
            m_ready <= 1'b0;
            hold_off <= hold_off + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_request(input logic op, input logic [15:0] value);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_sample <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic random_request();
        logic [15:0] v;
        case ($urandom_range(3))
            0: v = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1: v = 16'(16'h8000 + $urandom_range(15) - 8);
            default: v = 16'($urandom);
        endcase
        send_request(($urandom_range(19) == 0) ? OP_CLEAR : OP_PUSH, v);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_request(OP_PUSH, 16'hFFFF);
        send_request(OP_PUSH, 16'h0000);
        send_request(OP_PUSH, 16'hFFFF);
        send_request(OP_PUSH, 16'hFFFF);
        for (int i = 0; i < 6; i++) send_request(OP_PUSH, 16'hFFFF);
        send_request(OP_CLEAR, 16'h1234);
        send_request(OP_CLEAR, 16'hFFFF);
        for (int i = 0; i < 10; i++) send_request(OP_PUSH, 16'(i * 7001));
        send_request(OP_CLEAR, 16'h0000);
        send_request(OP_PUSH, 16'h5555);
        send_request(OP_PUSH, 16'hAAAA);
        hold_req <= 1'b1;
        for (int i = 0; i < 40; i++) random_request();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 50 : (ph == 3) ? 17 : 0;
            stall_pct = (ph == 2) ? 50 : (ph == 3) ? 17 : 0;
            for (int i = 0; i < 290; i++) random_request();
        end
        s_valid <= 1'b0;
        stall_pct = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("trimmed_window_stats test passed");
        else
            $display("trimmed_window_stats test failed");
        $finish;
    end
endmodule
